FILE: rtl/anbx_pkg.sv
// Shared types, constants and NAL header decode for the Annex B sample splitter.
`timescale 1ns / 1ps
package anbx_pkg;

  // Offset counter width and result field width
  localparam int OFFSET_BITS = 32;
  localparam int FIELD_BITS  = 32;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  localparam offset_t OFFSET_MAX = '1;

  // Configuration registers
  localparam int CFG_DATA_BITS = 3;
  typedef logic [1:0] codec_mode_t;
  typedef logic [2:0] sc_len_t;
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_CODEC_MODE = 1'b0;
  localparam cfg_idx_t REG_SC_LEN     = 1'b1;
  localparam codec_mode_t CODEC_H264     = 2'd0;
  localparam codec_mode_t CODEC_H265     = 2'd1;
  localparam codec_mode_t CODEC_MODE_RST = CODEC_H264;
  localparam sc_len_t     SC_LEN_RST     = 3'd3;

  // Header field masks
  localparam logic [7:0] H264_TYPE_MASK = 8'b0001_1111;
  localparam logic [7:0] H265_TYPE_MASK = 8'b0111_1110;

  // NAL unit types
  localparam logic [4:0] H264_IDR = 5'd5;
  localparam logic [4:0] H264_SPS = 5'd7;
  localparam logic [4:0] H264_PPS = 5'd8;
  localparam logic [5:0] H265_IDR_W_RADL = 6'd19;
  localparam logic [5:0] H265_IDR_N_LP   = 6'd20;
  localparam logic [5:0] H265_CRA        = 6'd21;
  localparam logic [5:0] H265_VPS        = 6'd32;
  localparam logic [5:0] H265_SPS        = 6'd33;
  localparam logic [5:0] H265_PPS        = 6'd34;

  // Start code marker byte
  localparam logic [7:0] SC_MARKER = 8'h01;
  localparam logic [1:0] ZERO_RUN_MAX = 2'd3;

  // Result queue
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [FIELD_BITS-1:0] sample_start;
    logic [FIELD_BITS-1:0] sample_end;
    logic                  is_config;
    logic                  is_key;
    logic [31:0]           sample_index;
    logic                  last_result;
  } sample_t;

  // Up to two samples leave the parser per transfer
  typedef struct packed {
    logic [1:0] count;
    sample_t    first;
    sample_t    second;
  } push_t;

  typedef struct packed {
    logic csd;
    logic key;
  } nal_class_t;

  // Classify a NAL header byte as parameter set and/or key picture
  function automatic nal_class_t classify(codec_mode_t mode, logic [7:0] hdr);
    logic [4:0] t264;
    logic [5:0] t265;
    nal_class_t c;
    t264 = 5'(hdr & H264_TYPE_MASK);
    t265 = 6'((hdr & H265_TYPE_MASK) >> 1);
    c    = '0;
    unique case (mode)
      CODEC_H264: begin
        c.csd = (t264 == H264_SPS) || (t264 == H264_PPS);
        c.key = (t264 == H264_IDR);
      end
      CODEC_H265: begin
        c.csd = (t265 == H265_VPS) || (t265 == H265_SPS) || (t265 == H265_PPS);
        c.key = (t265 == H265_IDR_W_RADL) || (t265 == H265_IDR_N_LP) ||
                (t265 == H265_CRA);
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  // Offset to result field width
  function automatic logic [FIELD_BITS-1:0] to_field(offset_t o);
    return FIELD_BITS'(o);
  endfunction

endpackage

FILE: rtl/anbx_if.sv
// Stream interfaces: byte input channel and sample result channel.
`timescale 1ns / 1ps
interface anbx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface anbx_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_start;
  logic [31:0] sample_end;
  logic        is_config;
  logic        is_key;
  logic [31:0] sample_index;
  logic        last_result;

  modport source (output valid, output sample_start, output sample_end, output is_config,
                  output is_key, output sample_index, output last_result, input ready);
  modport sink   (input valid, input sample_start, input sample_end, input is_config,
                  input is_key, input sample_index, input last_result, output ready);
endinterface

FILE: rtl/annexb_nal_sample_splitter.sv
// Top level: Annex B byte stream in, NAL samples with offsets and flags out.
//
//  channel     dir  payload                                          transfer when
//  byte_i      in   byte_value[7:0], last_byte                       valid & ready
//  sample_o    out  sample_start, sample_end, is_config, is_key,     valid & ready
//                   sample_index, last_result
//  cfg_*       in   cfg_idx_i, cfg_data_i[2:0]                       cfg_we_i
//
// One byte per cycle while the result queue has room; a result is offered once its
// byte has passed the input register and been written to the four-entry result queue.
// A header on the final byte yields two samples in one cycle; the queue absorbs them
// and input stalls only when fewer than two queue entries are free.
// Reset clears all stream state; codec_mode resets to H.264, the start code length to 3.
// A stalled sample output holds its result; input keeps flowing until three results wait.
`timescale 1ns / 1ps
module annexb_nal_sample_splitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  anbx_pkg::cfg_idx_t  cfg_idx_i,
  input  logic [anbx_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  anbx_byte_if.sink           byte_i,
  anbx_sample_if.source       sample_o
);
  import anbx_pkg::*;

  push_t   push;
  logic    space_ok;
  sample_t head;

  // Parser with input register
  anbx_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (byte_i.valid),
    .in_ready_o   (byte_i.ready),
    .byte_value_i (byte_i.byte_value),
    .last_byte_i  (byte_i.last_byte),
    .space_ok_i   (space_ok),
    .push_o       (push)
  );

  // Result queue
  anbx_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (sample_o.valid),
    .out_ready_i (sample_o.ready),
    .out_data_o  (head)
  );

  assign sample_o.sample_start = head.sample_start;
  assign sample_o.sample_end   = head.sample_end;
  assign sample_o.is_config    = head.is_config;
  assign sample_o.is_key       = head.is_key;
  assign sample_o.sample_index = head.sample_index;
  assign sample_o.last_result  = head.last_result;

endmodule

FILE: rtl/anbx_parser.sv
// Input register, start code detection, NAL grouping and sample emission.
`timescale 1ns / 1ps
module anbx_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  anbx_pkg::cfg_idx_t    cfg_idx_i,
  input  logic [anbx_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            byte_value_i,
  input  logic                  last_byte_i,
  input  logic                  space_ok_i,
  output anbx_pkg::push_t       push_o
);
  import anbx_pkg::*;

  // Configuration registers
  codec_mode_t codec_mode_q;
  sc_len_t     sc_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_mode_q <= CODEC_MODE_RST;
      sc_len_q     <= SC_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CODEC_MODE: codec_mode_q <= codec_mode_t'(cfg_data_i);
        REG_SC_LEN:     sc_len_q     <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       fire;

  assign fire       = in_valid_q && space_ok_i;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= byte_value_i;
      last_q <= last_byte_i;
    end
  end

  // Stream state
  offset_t     byte_offset_q, byte_offset_d;
  logic [1:0]  zero_run_q, zero_run_d;
  logic        header_next_q, header_next_d;
  offset_t     code_pos_q, code_pos_d;
  logic        pend_valid_q, pend_valid_d;
  offset_t     pend_start_q, pend_start_d;
  logic        pend_config_q, pend_config_d;
  logic        pend_key_q, pend_key_d;
  logic [31:0] count_q, count_d;

  logic       [1:0] need;
  nal_class_t       cls;
  logic             replace;
  logic             emit_open;
  logic             detect;
  offset_t          stream_len;
  sample_t          open_res;
  sample_t          final_res;
  logic             emit_final;

  always_comb begin
    need = sc_len_q[2] ? 2'd3 : 2'd2;
    cls  = classify(codec_mode_q, byte_q);

    // A header byte opens a new sample unless it extends a config run
    replace   = header_next_q && !(pend_valid_q && pend_config_q && cls.csd);
    emit_open = replace && pend_valid_q;

    open_res.sample_start = to_field(pend_start_q);
    open_res.sample_end   = to_field(code_pos_q);
    open_res.is_config    = pend_config_q;
    open_res.is_key       = pend_key_q;
    open_res.sample_index = count_q;
    open_res.last_result  = 1'b0;

    pend_valid_d  = pend_valid_q || header_next_q;
    pend_start_d  = replace ? code_pos_q : pend_start_q;
    pend_config_d = replace ? cls.csd : pend_config_q;
    pend_key_d    = replace ? (!cls.csd && cls.key) : pend_key_q;
    count_d       = count_q + 32'(emit_open);

    // Start code detection on the marker byte
    detect = (byte_q == SC_MARKER) && (zero_run_q >= need) &&
             (byte_offset_q >= OFFSET_BITS'(need));
    header_next_d = detect;
    code_pos_d    = detect ? (byte_offset_q - OFFSET_BITS'(need)) : code_pos_q;

    if (byte_q == 8'h00) begin
      zero_run_d = (zero_run_q == ZERO_RUN_MAX) ? zero_run_q : zero_run_q + 2'd1;
    end else begin
      zero_run_d = 2'd0;
    end

    // End of stream closes the open sample
    stream_len = (byte_offset_q == OFFSET_MAX) ? OFFSET_MAX : byte_offset_q + 1'b1;
    emit_final = last_q && pend_valid_d;

    final_res.sample_start = to_field(pend_start_d);
    final_res.sample_end   = to_field(stream_len);
    final_res.is_config    = pend_config_d;
    final_res.is_key       = pend_key_d;
    final_res.sample_index = count_d;
    final_res.last_result  = 1'b1;

    byte_offset_d = (byte_offset_q == OFFSET_MAX) ? byte_offset_q : byte_offset_q + 1'b1;

    // Pack results in order for the queue
    push_o = '0;
    if (fire) begin
      push_o.count = 2'(emit_open) + 2'(emit_final);
      if (emit_open) begin
        push_o.first  = open_res;
        push_o.second = final_res;
      end else begin
        push_o.first  = final_res;
        push_o.second = final_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q <= '0;
      zero_run_q    <= '0;
      header_next_q <= 1'b0;
      code_pos_q    <= '0;
      pend_valid_q  <= 1'b0;
      pend_start_q  <= '0;
      pend_config_q <= 1'b0;
      pend_key_q    <= 1'b0;
      count_q       <= '0;
    end else if (fire) begin
      if (last_q) begin
        // New stream begins after the last byte
        byte_offset_q <= '0;
        zero_run_q    <= '0;
        header_next_q <= 1'b0;
        code_pos_q    <= '0;
        pend_valid_q  <= 1'b0;
        pend_start_q  <= '0;
        pend_config_q <= 1'b0;
        pend_key_q    <= 1'b0;
        count_q       <= '0;
      end else begin
        byte_offset_q <= byte_offset_d;
        zero_run_q    <= zero_run_d;
        header_next_q <= header_next_d;
        code_pos_q    <= code_pos_d;
        pend_valid_q  <= pend_valid_d;
        pend_start_q  <= pend_start_d;
        pend_config_q <= pend_config_d;
        pend_key_q    <= pend_key_d;
        count_q       <= count_d;
      end
    end
  end

`ifndef SYNTHESIS
  // Two results only come from a header on the final byte
  a_two_results_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (push_o.second.last_result && !push_o.first.last_result &&
                                last_q && header_next_q))
    else $error("second result without header on final byte");

  a_index_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |->
      (push_o.second.sample_index == push_o.first.sample_index + 32'd1))
    else $error("sample indexes of paired results not consecutive");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last_q) |=> (!pend_valid_q && !header_next_q && byte_offset_q == '0))
    else $error("stream state not cleared after final byte");
`endif

endmodule

FILE: rtl/anbx_result_fifo.sv
// Small result queue taking up to two samples per cycle and releasing one.
`timescale 1ns / 1ps
module anbx_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  anbx_pkg::push_t   push_i,
  output logic              space_ok_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output anbx_pkg::sample_t out_data_o
);
  import anbx_pkg::*;

  sample_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] rd_ptr_q, wr_ptr_q, wr_ptr_p1;
  logic [FIFO_CNT_BITS-1:0] count_q;
  logic                     pop;

  assign wr_ptr_p1   = wr_ptr_q + 1'b1;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for a worst-case pair after this cycle
  assign space_ok_o  = (count_q <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));

  // Storage writes
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_p1] <= push_i.second;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(push_i.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + FIFO_CNT_BITS'(push_i.count) - FIFO_CNT_BITS'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0 && !pop) |=>
      (count_q == $past(count_q) + FIFO_CNT_BITS'($past(push_i.count))))
    else $error("fill count does not follow pushes");

  // A push always finds enough free entries
  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |->
      (count_q <= FIFO_CNT_BITS'(FIFO_DEPTH) - FIFO_CNT_BITS'(push_i.count)))
    else $error("push without room in result queue");
`endif

endmodule
